### rtl/core/rpac_pkg.sv
// Shared constants and types for the point rotation pipeline.
// Holds the CORDIC arctangent table, the gain constant and the quadrant codes.
// No dependencies.
package rpac_pkg;

    // Extra fraction bits carried through the rotation datapath.
    localparam int GUARD_BITS = 8;

    // Angles inside the datapath are held in 2^-32 turn units.
    localparam int TURN_BITS = 32;

    // Number of entries in the arctangent table.
    localparam int TABLE_LEN = 24;

    // Inverse CORDIC gain, 0.60725293... in Q30.
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    typedef logic [TURN_BITS-1:0] t_turn;

    // Quadrant selected by the top angle bits, rounded to the nearest quarter turn.
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } t_quadrant;

    // Arctangent of 2^-i in 2^-32 turn units.
    localparam t_turn ATAN_TURN [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage

### rtl/core/rpac_prep.sv
// Front end of the rotation pipeline: offset from center, angle split and
// exact quarter-turn rotation, in two register stages. Uses rpac_pkg.
module rpac_prep import rpac_pkg::*; #(
    parameter int CW = 32,
    parameter int AB = 16,
    parameter int W  = 44
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_px,
    input  logic signed [CW-1:0] i_py,
    input  logic signed [CW-1:0] i_cx,
    input  logic signed [CW-1:0] i_cy,
    input  logic [AB-1:0]        i_ang,
    output logic                 o_valid,
    output logic signed [W-1:0]  o_x,
    output logic signed [W-1:0]  o_y,
    output logic signed [31:0]   o_z
);

    logic                 r_v1;
    logic signed [CW:0]   r_dx;
    logic signed [CW:0]   r_dy;
    t_quadrant            r_q;
    logic signed [31:0]   r_z1;

    logic                 r_v2;
    logic signed [W-1:0]  r_x;
    logic signed [W-1:0]  r_y;
    logic signed [31:0]   r_z2;

    t_turn                full_turn;
    t_quadrant            n_q;
    logic signed [W-1:0]  n_x;
    logic signed [W-1:0]  n_y;

    // Widen the angle to a full 32-bit turn and round the quadrant to nearest.
    // The residue is kept in [-1/8, 1/8) turn as a sign-extended 30-bit value.
    always_comb begin
        full_turn = {i_ang, {(TURN_BITS-AB){1'b0}}};
        n_q       = t_quadrant'(full_turn[31:30] + {1'b0, full_turn[29]});
    end

    // Valid bits of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Stage one: offsets at full precision and the split angle.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx <= (CW+1)'(i_px) - (CW+1)'(i_cx);
            r_dy <= (CW+1)'(i_py) - (CW+1)'(i_cy);
            r_q  <= n_q;
            r_z1 <= signed'({{2{full_turn[29]}}, full_turn[29:0]});
        end
    end

    // Stage two: add guard bits and rotate by the selected quarter turn.
    always_comb begin
        logic signed [W-1:0] ex;
        logic signed [W-1:0] ey;
        ex = W'(r_dx) <<< GUARD_BITS;
        ey = W'(r_dy) <<< GUARD_BITS;
        case (r_q)
            QUAD_90: begin
                n_x = -ey;
                n_y = ex;
            end
            QUAD_180: begin
                n_x = -ex;
                n_y = -ey;
            end
            QUAD_270: begin
                n_x = ey;
                n_y = -ex;
            end
            default: begin
                n_x = ex;
                n_y = ey;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_z2 <= r_z1;
        end
    end

    assign o_valid = r_v2;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z2;

endmodule

### rtl/core/rpac_cstage.sv
// One CORDIC rotation stage with its own register, shift fixed by IDX.
// Uses the arctangent table of rpac_pkg.
module rpac_cstage import rpac_pkg::*; #(
    parameter int W   = 44,
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  logic signed [31:0]  i_z,
    output logic                o_valid,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output logic signed [31:0]  o_z
);

    localparam logic signed [31:0] STEP_ANGLE = signed'(ATAN_TURN[IDX]);

    logic                r_valid;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic signed [31:0]  r_z;

    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    logic signed [W-1:0] n_x;
    logic signed [W-1:0] n_y;
    logic signed [31:0]  n_z;

    // Arithmetic shifts floor; the sign of the residual angle picks the direction.
    always_comb begin
        xs = i_x >>> IDX;
        ys = i_y >>> IDX;
        if (!i_z[31]) begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - STEP_ANGLE;
        end else begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + STEP_ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

### rtl/core/rpac_gain.sv
// CORDIC gain correction for one coordinate: magnitude, split multiply by the
// Q30 gain, rounding and sign restore over four register stages. Uses rpac_pkg.
module rpac_gain import rpac_pkg::*; #(
    parameter int W = 44
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_v,
    output logic                o_valid,
    output logic signed [W-1:0] o_v
);

    // Magnitude width, at least one bit above the low 32-bit partial product.
    localparam int MW = (W > 33) ? W : 33;
    localparam int HW = MW - 32;
    localparam int SW = MW + 30;
    localparam logic [SW-1:0] HALF_LSB = SW'(1) << 29;

    logic [3:0]           r_valid;

    logic                 r_neg1;
    logic [MW-1:0]        r_m;
    logic                 r_neg2;
    logic [61:0]          r_plo;
    logic [HW+29:0]       r_phi;
    logic                 r_neg3;
    logic [W-1:0]         r_r;
    logic signed [W-1:0]  r_out;

    logic [SW-1:0]        n_sum;

    // Valid bits travel with the four stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    // Sum of the partial products plus one half in the Q30 position.
    assign n_sum = {r_phi, 32'd0} + SW'(r_plo) + HALF_LSB;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Stage one: sign and magnitude.
            r_neg1 <= i_v[W-1];
            r_m    <= MW'($unsigned(i_v[W-1] ? -i_v : i_v));
            // Stage two: low and high partial products.
            r_neg2 <= r_neg1;
            r_plo  <= r_m[31:0] * GAIN_Q30;
            r_phi  <= r_m[MW-1:32] * GAIN_Q30;
            // Stage three: round the scaled magnitude to nearest.
            r_neg3 <= r_neg2;
            r_r    <= n_sum[30 +: W];
            // Stage four: restore the sign.
            r_out  <= r_neg3 ? -signed'(r_r) : signed'(r_r);
        end
    end

    assign o_valid = r_valid[3];
    assign o_v     = r_out;

endmodule

### rtl/core/rpac_finish.sv
// Back end for one coordinate: drops the guard bits with rounding in a register
// stage, then adds the center and saturates. Uses rpac_pkg.
module rpac_finish import rpac_pkg::*; #(
    parameter int CW = 32,
    parameter int W  = 44
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [W-1:0]  i_v,
    input  logic signed [CW-1:0] i_center,
    output logic                 o_valid,
    output logic signed [CW-1:0] o_result
);

    localparam int RW = W - GUARD_BITS;
    localparam logic signed [W-1:0] ROUND_HALF = W'(1) << (GUARD_BITS - 1);

    logic                 r_valid;
    logic signed [RW-1:0] r_rnd;
    logic signed [W-1:0]  n_tmp;
    logic signed [RW:0]   sum;
    logic                 ovf;

    // Round to nearest with ties toward plus infinity, then floor by the guard bits.
    assign n_tmp = i_v + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rnd <= n_tmp[W-1:GUARD_BITS];
        end
    end

    // Add the center back; saturate when the bits above the coordinate range
    // disagree with the sign.
    always_comb begin
        sum = (RW+1)'(r_rnd) + (RW+1)'(i_center);
        ovf = !((&sum[RW:CW-1]) || !(|sum[RW:CW-1]));
        if (ovf) begin
            o_result = {sum[RW], {(CW-1){~sum[RW]}}};
        end else begin
            o_result = sum[CW-1:0];
        end
    end

    assign o_valid = r_valid;

endmodule

### rtl/core/rotate_point_about_center.sv
// Rotates a point about a center by a binary angle with a pipelined CORDIC.
// Register order: prep, CORDIC (stage count capped at 24), gain, rounding, output.
// Takes one request per cycle while o_ready is high; one register per CORDIC stage.
// A held result stalls the pipeline only when the last stage also holds a request.
// Reset clears the valid bits only; the datapath registers keep their contents.
module rotate_point_about_center import rpac_pkg::*; #(
    parameter int COORD_WIDTH   = 32,
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    input  logic [ANGLE_BITS-1:0]         i_turn_angle,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_rotated_x,
    output logic signed [COORD_WIDTH-1:0] o_rotated_y
);

    localparam int CW     = COORD_WIDTH;
    localparam int W      = COORD_WIDTH + GUARD_BITS + 4;
    localparam int NS     = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    // Prep (2), CORDIC (NS), gain (4), rounding (1).
    localparam int CDEPTH = NS + 7;

    logic                 ce;
    logic                 load;

    logic                 s_valid [0:NS];
    logic signed [W-1:0]  s_x     [0:NS];
    logic signed [W-1:0]  s_y     [0:NS];
    logic signed [31:0]   s_z     [0:NS];

    logic                 gx_valid;
    logic                 gy_valid;
    logic signed [W-1:0]  gx_v;
    logic signed [W-1:0]  gy_v;

    logic                 fx_valid;
    logic                 fy_valid;
    logic signed [CW-1:0] fx_res;
    logic signed [CW-1:0] fy_res;

    logic signed [CW-1:0] r_cx_dly [0:CDEPTH-1];
    logic signed [CW-1:0] r_cy_dly [0:CDEPTH-1];

    logic                 r_out_valid;
    logic signed [CW-1:0] r_out_x;
    logic signed [CW-1:0] r_out_y;

    // The pipeline moves unless a finished request waits behind a held result.
    assign ce      = !(fx_valid && r_out_valid && !i_ready);
    assign load    = fx_valid && ce;
    assign o_ready = ce;

    rpac_prep #(
        .CW (CW),
        .AB (ANGLE_BITS),
        .W  (W)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (ce),
        .i_valid (i_valid),
        .i_px    (i_point_x),
        .i_py    (i_point_y),
        .i_cx    (i_center_x),
        .i_cy    (i_center_y),
        .i_ang   (i_turn_angle),
        .o_valid (s_valid[0]),
        .o_x     (s_x[0]),
        .o_y     (s_y[0]),
        .o_z     (s_z[0])
    );

    // CORDIC chain, one registered stage per iteration.
    for (genvar gi = 0; gi < NS; gi++) begin : g_cordic
        rpac_cstage #(
            .W   (W),
            .IDX (gi)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (ce),
            .i_valid (s_valid[gi]),
            .i_x     (s_x[gi]),
            .i_y     (s_y[gi]),
            .i_z     (s_z[gi]),
            .o_valid (s_valid[gi+1]),
            .o_x     (s_x[gi+1]),
            .o_y     (s_y[gi+1]),
            .o_z     (s_z[gi+1])
        );
    end

    rpac_gain #(.W(W)) u_gain_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (ce),
        .i_valid (s_valid[NS]),
        .i_v     (s_x[NS]),
        .o_valid (gx_valid),
        .o_v     (gx_v)
    );

    rpac_gain #(.W(W)) u_gain_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (ce),
        .i_valid (s_valid[NS]),
        .i_v     (s_y[NS]),
        .o_valid (gy_valid),
        .o_v     (gy_v)
    );

    // The center travels alongside the datapath to the final add.
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_cx_dly[0] <= i_center_x;
            r_cy_dly[0] <= i_center_y;
            for (int k = 1; k < CDEPTH; k++) begin
                r_cx_dly[k] <= r_cx_dly[k-1];
                r_cy_dly[k] <= r_cy_dly[k-1];
            end
        end
    end

    rpac_finish #(
        .CW (CW),
        .W  (W)
    ) u_fin_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (ce),
        .i_valid  (gx_valid),
        .i_v      (gx_v),
        .i_center (r_cx_dly[CDEPTH-1]),
        .o_valid  (fx_valid),
        .o_result (fx_res)
    );

    rpac_finish #(
        .CW (CW),
        .W  (W)
    ) u_fin_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (ce),
        .i_valid  (gy_valid),
        .i_v      (gy_v),
        .i_center (r_cy_dly[CDEPTH-1]),
        .o_valid  (fy_valid),
        .o_result (fy_res)
    );

    // Output register: loads a finished request, clears when the result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= fy_valid;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_x <= fx_res;
            r_out_y <= fy_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_rotated_x = r_out_x;
    assign o_rotated_y = r_out_y;

endmodule
